// ===== rtl/dpt_pkg.sv =====
// shared types and constants for the deterministic primality test unit
// no dependencies
package dpt_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned NumBases = 12;
  localparam int unsigned BaseIdxW = 4;

  typedef logic [WordW-1:0] word_t;

  // modular multiplier request/response
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mm_rsp_t;

  function automatic word_t base_of(input logic [BaseIdxW-1:0] idx);
    word_t r;
    r = '0;
    case (idx)
      4'd0:  r = 64'd2;
      4'd1:  r = 64'd3;
      4'd2:  r = 64'd5;
      4'd3:  r = 64'd7;
      4'd4:  r = 64'd11;
      4'd5:  r = 64'd13;
      4'd6:  r = 64'd17;
      4'd7:  r = 64'd19;
      4'd8:  r = 64'd23;
      4'd9:  r = 64'd29;
      4'd10: r = 64'd31;
      4'd11: r = 64'd37;
      default: r = 64'd2;
    endcase
    return r;
  endfunction

  // number of bases needed for an odd n
  function automatic logic [BaseIdxW:0] base_count(input word_t n);
    logic [BaseIdxW:0] k;
    if (n < 64'd2047) k = 5'd1;
    else if (n < 64'd1373653) k = 5'd2;
    else if (n < 64'd25326001) k = 5'd3;
    else if (n < 64'd3215031751) k = 5'd4;
    else if (n < 64'd2152302898747) k = 5'd5;
    else if (n < 64'd3474749660383) k = 5'd6;
    else if (n < 64'd341550071728321) k = 5'd7;
    else if (n < 64'd3825123056546413051) k = 5'd9;
    else k = 5'd12;
    return k;
  endfunction

endpackage

// ===== rtl/dpt_mulmod.sv =====
// shift-and-add modular multiplier, one bit of b per cycle
// depends on dpt_pkg
module dpt_mulmod
  import dpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  word_t acc, a, b, m;
  logic  busy;
  logic  done;

  word_t acc_sum, acc_next, a_dbl, a_next;

  // operands stay below m < 2^63, so sums fit in 64 bits
  always_comb begin
    acc_sum  = acc + a;
    acc_next = (acc_sum >= m) ? acc_sum - m : acc_sum;
    if (!b[0]) acc_next = acc;
    a_dbl    = {a[WordW-2:0], 1'b0};
    a_next   = (a_dbl >= m) ? a_dbl - m : a_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && b == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      a   <= req.a;
      b   <= req.b;
      m   <= req.m;
    end else if (busy && b != '0) begin
      acc <= acc_next;
      a   <= a_next;
      b   <= {1'b0, b[WordW-1:1]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

// ===== rtl/deterministic_primality_test_unit.sv =====
// Deterministic Miller-Rabin primality test for one signed 64-bit value.
// Item in on s_axis (tdata = candidate), one result on m_axis (tdata bit 0 = is_prime).
// Input is taken only when idle; a new item is accepted while the previous
// result waits in the output register, since that register is free once the
// test loop ends. Trivial cases (<= 1, even, 3) skip the test loop.
// Odd values run up to 12 bases; each base needs at most about 126 modular
// multiplications (a square per exponent bit, a product per set exponent bit,
// then up to s-1 witness squarings), each run in turn on the single
// shift-and-add multiplier; small n need far fewer bases.
// The multiplier does the modular arithmetic and sets the rate.
// The result stays on m_axis until taken; while the receiver stalls and the
// result register is full, a finished test waits before writing its result.
// Synchronous reset rst clears the sequencer and drops all valid flags.
// A new item is taken only after the previous test has finished.
// Reset sets no data registers.
// Depends on dpt_pkg and dpt_mulmod.
module deterministic_primality_test_unit
  import dpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [63:0] candidate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] is_prime, [7:1] zero
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SPLIT  = 9'b000000010,
    S_BASE   = 9'b000000100,
    S_PSQ    = 9'b000001000,
    S_PMUL   = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_SQ     = 9'b001000000,
    S_SQCHK  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  word_t  n, d, e, r, x;
  logic [5:0] s, j;
  logic [BaseIdxW:0] k, i;
  logic   verdict;
  logic   out_valid, out_bit;
  logic   issue;
  mm_req_t req;
  mm_rsp_t rsp;

  dpt_mulmod u_mulmod (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  word_t nm1;
  assign nm1 = n - 64'd1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_bit};

  // multiplier start pulse for the next cycle
  always_comb begin
    issue = 1'b0;
    if (state == S_PMUL) begin
      issue = (e != '0) && !req.start && (rsp.done || !e[0] || j != 6'd63);
    end else if (state == S_SQ) begin
      issue = (j < s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= issue;
      out_valid <= (state == S_DONE && (!out_valid || m_axis_tready)) ||
                   (out_valid && !m_axis_tready);
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            n <= s_axis_tdata;
            if (s_axis_tdata[63] || s_axis_tdata <= 64'd1) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else if (!s_axis_tdata[0]) begin
              verdict <= (s_axis_tdata == 64'd2);
              state   <= S_DONE;
            end else if (s_axis_tdata == 64'd3) begin
              verdict <= 1'b1;
              state   <= S_DONE;
            end else begin
              d     <= s_axis_tdata - 64'd1;
              s     <= '0;
              k     <= base_count(s_axis_tdata);
              i     <= '0;
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          // strip one factor of two per cycle
          if (!d[0]) begin
            d <= {1'b0, d[WordW-1:1]};
            s <= s + 6'd1;
          end else begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          if (i == k) begin
            verdict <= 1'b1;
            state   <= S_DONE;
          end else begin
            // only base 2 is used below 2047, so every base is already below n
            x     <= base_of(i[BaseIdxW-1:0]);
            r     <= 64'd1;
            e     <= d;
            j     <= '0;
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          // r *= x when the exponent bit is set
          if (e == '0) begin
            state <= S_CHECK;
          end else if (!req.start && rsp.done) begin
            r     <= rsp.prod;
            state <= S_PSQ;
            req.a <= x; req.b <= x; req.m <= n;
          end else if (!req.start && !e[0]) begin
            state <= S_PSQ;
            req.a <= x; req.b <= x; req.m <= n;
          end else if (!req.start && e[0] && j != 6'd63) begin
            j <= 6'd63;
            req.a <= r; req.b <= x; req.m <= n;
          end
        end
        S_PSQ: begin
          if (!req.start && rsp.done) begin
            x     <= rsp.prod;
            e     <= {1'b0, e[WordW-1:1]};
            j     <= '0;
            state <= S_PMUL;
          end
        end
        S_CHECK: begin
          if (r == 64'd1 || r == nm1) begin
            i     <= i + 5'd1;
            state <= S_BASE;
          end else begin
            j     <= 6'd1;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (j >= s) begin
            verdict <= 1'b0;
            state   <= S_DONE;
          end else begin
            req.a <= r; req.b <= r; req.m <= n;
            state <= S_SQCHK;
          end
        end
        S_SQCHK: begin
          if (!req.start && rsp.done) begin
            r <= rsp.prod;
            if (rsp.prod == nm1) begin
              i     <= i + 5'd1;
              state <= S_BASE;
            end else begin
              j     <= j + 6'd1;
              state <= S_SQ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_bit   <= verdict;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_deterministic_primality_test_unit.sv =====
// testbench for deterministic_primality_test_unit: directed table then random candidates,
// each result checked against the table's known verdict or a local miller-rabin model; depends on dpt_pkg and the rtl
module tb_deterministic_primality_test_unit
  import dpt_pkg::*;
();

  localparam int unsigned IdleLimit = 1000000;
  localparam int unsigned HoldCycles = 200000;
  localparam int unsigned RandItems = 78;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] candidate
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] is_prime, [7:1] zero

  deterministic_primality_test_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  typedef struct {
    logic [63:0] cand;
    int          known;  // -1: take from the model
  } dir_row_t;

  bit [7:0] verdict_q[$];
  int       tx_idle;
  int       rx_idle;
  bit       hold_go;
  int       errors;
  int       quiet_cycles;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // ---------------- model ----------------
  function automatic word_t mul_mod(word_t a, word_t b, word_t m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t m);
    word_t r;
    r = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic bit prime_verdict(word_t n);
    word_t bounds [8];
    int    counts [9];
    word_t primes [12];
    word_t d, x;
    int    s, k, i, j;
    bit    ok;
    bounds = '{64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751, 64'd2152302898747,
               64'd3474749660383, 64'd341550071728321, 64'd3825123056546413051};
    counts = '{1, 2, 3, 4, 5, 6, 7, 9, 12};
    primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (n[63] || n <= 1) return 1'b0;
    if (!n[0]) return n == 2;
    if (n == 3) return 1'b1;
    k = counts[8];
    for (i = 7; i >= 0; i--)
      if (n < bounds[i]) k = counts[i];
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (i = 0; i < k; i++) begin
      x = pow_mod(primes[i], d, n);
      if (x == 1 || x == n - 1) continue;
      ok = 1'b0;
      for (j = 1; j < s && !ok; j++) begin
        x = mul_mod(x, x, n);
        if (x == n - 1) ok = 1'b1;
      end
      if (!ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------- stimulus ----------------
  task automatic offer(input logic [63:0] cand, input int known);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cand;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    verdict_q.push_back({7'd0, (known >= 0) ? known[0] : prime_verdict(cand)});
  endtask

  function automatic logic [63:0] rand_candidate();
    int unsigned sel;
    logic [63:0] v;
    sel = $urandom_range(99);
    if (sel < 45) v = {44'd0, 20'($urandom)} | 64'd1;
    else if (sel < 65) v = {32'd0, $urandom};
    else if (sel < 80) begin
      // full width, kept cheap: negative or even
      v = {$urandom, $urandom};
      if (!v[63]) v[0] = 1'b0;
    end else if (sel < 95) v = 64'($urandom_range(64));
    else v = {1'b0, 31'($urandom), $urandom} | 64'd1;
    return v;
  endfunction

  initial begin
    dir_row_t rows [$];
    int i;
    rows = '{
      '{64'h8000_0000_0000_0000, 0}, '{64'hFFFF_FFFF_FFFF_FFFF, 0},
      '{64'd0, 0}, '{64'd1, 0}, '{64'd2, 1}, '{64'd3, 1}, '{64'd4, 0},
      '{64'd9, 0}, '{64'd5, -1}, '{64'd2047, 0}, '{64'd2053, -1},
      '{64'd1373653, 0}, '{64'd25326001, 0}, '{64'd3215031751, 0},
      '{64'd2152302898747, 0}, '{64'd3474749660383, 0},
      '{64'd341550071728321, 0}, '{64'd3825123056546413051, 0},
      '{64'h1FFF_FFFF_FFFF_FFFF, 1}, '{64'h7FFF_FFFF_FFFF_FFFF, 0},
      '{64'h7FFF_FFFF_FFFF_FFFE, 0}, '{64'd4294967291, -1}
    };
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_go = 1'b0;
    tx_idle = 29;
    rx_idle = 73;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[j]) offer(rows[j].cand, rows[j].known);
    for (i = 0; i < RandItems; i++) begin
      if (i == RandItems / 3) begin
        tx_idle = 73;
        rx_idle = 29;
      end else if (i == 2 * RandItems / 3) begin
        tx_idle = 0;
        rx_idle = 0;
        hold_go = 1'b1;
      end
      offer(rand_candidate(), -1);
    end
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("** deterministic_primality_test_unit: PASSED **");
    else $display("** deterministic_primality_test_unit: FAILED **");
    $finish;
  end

  // receiver side, with one long hold-off to back the block up
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // ---------------- checking ----------------
  always @(posedge clk) begin
    bit [7:0] want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("** deterministic_primality_test_unit: FAILED **");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %h", m_axis_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== want) begin
            errors++;
            if (errors <= 10)
              $display("is_prime mismatch: expected %h, got %h", want, m_axis_tdata);
          end
        end
      end
    end
  end

endmodule

// ===== deterministic_primality_test_unit.f =====
rtl/dpt_pkg.sv
rtl/dpt_mulmod.sv
rtl/deterministic_primality_test_unit.sv
sim/tb_deterministic_primality_test_unit.sv
